>>> src/uul1_pkg.sv
// ----------------------------------------------------------------------------
// uul1_pkg
// Shared types, constants and helpers for the URL unescape / UTF-8 to
// Latin-1 converter.
// ----------------------------------------------------------------------------
package uul1_pkg;

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_PCT   = 8'h25;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    localparam logic [7:0] REPL_CHAR_RESET = 8'd95;

    // One decoded byte handed from the escape stage to the UTF-8 stage.
    // end_raw: the string ends after this byte (raw zero seen).
    typedef struct packed {
        logic       en;
        logic [7:0] data;
        logic       end_raw;
    } t_feed;

    // Loose hex mapping: digits and 'A'-'F' as usual, anything else c-0x57.
    function automatic logic [7:0] hex_nibble(input logic [7:0] c);
        logic [7:0] r;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = c - 8'h30;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = c - 8'h37;
        end else begin
            r = c - 8'h57;
        end
        return r;
    endfunction

endpackage

>>> src/uul1_ifs.sv
// ----------------------------------------------------------------------------
// uul1 stream interfaces
// Valid/ready channels for raw input bytes and decoded result items.
// ----------------------------------------------------------------------------
interface uul1_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_in;

    modport source (output valid, output in_byte, output last_in, input ready);
    modport sink   (input valid, input in_byte, input last_in, output ready);
endinterface

interface uul1_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] latin1_byte;
    logic       byte_valid;
    logic       end_of_string;
    logic       status;

    modport source (output valid, output latin1_byte, output byte_valid,
                    output end_of_string, output status, input ready);
    modport sink   (input valid, input latin1_byte, input byte_valid,
                    input end_of_string, input status, output ready);
endinterface

>>> src/uul1_pct_dec.sv
// ----------------------------------------------------------------------------
// uul1_pct_dec
// Percent-escape decoder: turns raw characters into decoded bytes.
// ----------------------------------------------------------------------------
module uul1_pct_dec import uul1_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  logic       i_blocked,
    output t_feed      o_feed
);

    typedef enum logic [1:0] {
        ESC_IDLE,
        ESC_HIGH,
        ESC_LOW
    } t_esc_phase;

    t_esc_phase r_phase, n_phase;
    logic [7:0] r_esc_val, n_esc_val;
    logic [7:0] nib;

    always_comb begin
        nib       = hex_nibble(i_byte);
        n_phase   = r_phase;
        n_esc_val = r_esc_val;
        o_feed    = '0;
        if (!i_blocked) begin
            unique case (r_phase)
                ESC_IDLE: begin
                    if (i_byte == CHAR_NUL) begin
                        o_feed.end_raw = 1'b1;
                    end else if (i_byte == CHAR_PCT) begin
                        n_phase = ESC_HIGH;
                    end else begin
                        o_feed.en   = 1'b1;
                        o_feed.data = (i_byte == CHAR_PLUS) ? CHAR_SPACE : i_byte;
                    end
                end
                ESC_HIGH: begin
                    if (i_byte == CHAR_NUL) begin
                        n_phase        = ESC_IDLE;
                        o_feed.end_raw = 1'b1;
                    end else begin
                        n_esc_val = {nib[3:0], 4'h0};
                        n_phase   = ESC_LOW;
                        // '%' plus one char at end: high digit goes out alone
                        if (i_last) begin
                            o_feed.en   = 1'b1;
                            o_feed.data = {nib[3:0], 4'h0};
                        end
                    end
                end
                ESC_LOW: begin
                    n_phase   = ESC_IDLE;
                    o_feed.en = 1'b1;
                    if (i_byte == CHAR_NUL) begin
                        o_feed.data    = r_esc_val;
                        o_feed.end_raw = 1'b1;
                    end else begin
                        o_feed.data = r_esc_val + nib;
                    end
                end
                default: begin
                    n_phase = ESC_IDLE;
                end
            endcase
        end
        if (i_last) begin
            n_phase   = ESC_IDLE;
            n_esc_val = 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= ESC_IDLE;
            r_esc_val <= 8'h00;
        end else if (i_en) begin
            r_phase   <= n_phase;
            r_esc_val <= n_esc_val;
        end
    end

endmodule

>>> src/uul1_utf8_dec.sv
// ----------------------------------------------------------------------------
// uul1_utf8_dec
// UTF-8 sequence decoder (1 to 6 byte forms) with Latin-1 mapping.
// ----------------------------------------------------------------------------
module uul1_utf8_dec import uul1_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  t_feed      i_feed,
    input  logic       i_last,
    input  logic [7:0] i_repl,
    output logic       o_blocked,
    output logic       o_out_en,
    output logic [7:0] o_out_byte,
    output logic       o_status
);

    localparam logic [7:0] LEAD_MIN = 8'hC2;
    localparam logic [7:0] LEAD_3B  = 8'hE0;
    localparam logic [7:0] LEAD_4B  = 8'hF0;
    localparam logic [7:0] LEAD_5B  = 8'hF8;
    localparam logic [7:0] LEAD_6B  = 8'hFC;
    localparam logic [7:0] LEAD_BAD = 8'hFE;

    logic [2:0]  r_rem, n_rem;
    logic [7:0]  r_lead, n_lead;
    logic        r_fcs, n_fcs;
    logic [30:0] r_accum, n_accum;
    logic        r_err, n_err;
    logic        r_term, n_term;
    logic [7:0]  d;
    logic        overlong;

    assign o_blocked = r_term | r_err;
    assign d         = i_feed.data;

    always_comb begin
        n_rem      = r_rem;
        n_lead     = r_lead;
        n_fcs      = r_fcs;
        n_accum    = r_accum;
        n_err      = r_err;
        n_term     = r_term;
        o_out_en   = 1'b0;
        o_out_byte = 8'h00;
        overlong   = ((r_lead == LEAD_3B) && (d < 8'hA0)) ||
                     ((r_lead == LEAD_4B) && (d < 8'h90)) ||
                     ((r_lead == LEAD_5B) && (d < 8'h88)) ||
                     ((r_lead == LEAD_6B) && (d < 8'h84));

        if (i_feed.en && !r_term && !r_err) begin
            if (d == CHAR_NUL) begin
                n_err  = r_err | (r_rem != 3'd0);
                n_term = 1'b1;
            end else if (r_rem == 3'd0) begin
                n_fcs  = 1'b0;
                n_lead = d;
                if (d < 8'h80) begin
                    o_out_en   = 1'b1;
                    o_out_byte = d;
                    n_lead     = r_lead;
                    n_fcs      = r_fcs;
                end else if (d < LEAD_MIN || d >= LEAD_BAD) begin
                    n_err  = 1'b1;
                    n_lead = r_lead;
                    n_fcs  = r_fcs;
                end else if (d < LEAD_3B) begin
                    n_rem   = 3'd1;
                    n_accum = {26'd0, d[4:0]};
                end else if (d < LEAD_4B) begin
                    n_rem   = 3'd2;
                    n_accum = {27'd0, d[3:0]};
                end else if (d < LEAD_5B) begin
                    n_rem   = 3'd3;
                    n_accum = {28'd0, d[2:0]};
                end else if (d < LEAD_6B) begin
                    n_rem   = 3'd4;
                    n_accum = {29'd0, d[1:0]};
                end else begin
                    n_rem   = 3'd5;
                    n_accum = {30'd0, d[0]};
                end
            end else if (d[7:6] != 2'b10) begin
                n_err = 1'b1;
            end else if (!r_fcs && overlong) begin
                n_err = 1'b1;
            end else begin
                n_fcs   = 1'b1;
                n_accum = {r_accum[24:0], d[5:0]};
                n_rem   = r_rem - 3'd1;
                if (r_rem == 3'd1) begin
                    o_out_en   = 1'b1;
                    o_out_byte = (n_accum[30:8] == 23'd0) ? n_accum[7:0] : i_repl;
                end
            end
        end

        // raw zero closes the string after any byte delivered with it
        if (i_feed.end_raw) begin
            n_err  = n_err | (n_rem != 3'd0);
            n_term = 1'b1;
        end

        o_status = n_err | (n_rem != 3'd0);

        if (i_last) begin
            n_rem   = 3'd0;
            n_lead  = 8'h00;
            n_fcs   = 1'b0;
            n_accum = 31'd0;
            n_err   = 1'b0;
            n_term  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem   <= 3'd0;
            r_lead  <= 8'h00;
            r_fcs   <= 1'b0;
            r_accum <= 31'd0;
            r_err   <= 1'b0;
            r_term  <= 1'b0;
        end else if (i_en) begin
            r_rem   <= n_rem;
            r_lead  <= n_lead;
            r_fcs   <= n_fcs;
            r_accum <= n_accum;
            r_err   <= n_err;
            r_term  <= n_term;
        end
    end

endmodule

>>> src/url_unescape_utf8_to_latin1_top.sv
// ----------------------------------------------------------------------------
// url_unescape_utf8_to_latin1_top
// URL percent-decoder followed by a UTF-8 to Latin-1 converter.
// ----------------------------------------------------------------------------
// Takes one raw byte of a URL-encoded string per clock cycle, last byte
// marked, and delivers decoded Latin-1 bytes. Each accepted byte lands in an
// input register; the escape and UTF-8 state update for it happens as the
// byte leaves that register, and its result (if any) is loaded into the
// output register, from which it is presented. The last byte of a string
// always yields one result carrying end_of_string and status. Sustained
// rate is one byte per cycle, set by the escape and UTF-8 sequence state
// being updated once per byte; the input stalls only while the output
// register holds a result the sink has not taken. replacement_char sits at
// APB byte address 0 and should be written only while the block is idle.
module url_unescape_utf8_to_latin1_top import uul1_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    uul1_in_if.sink               i_in,
    uul1_out_if.source            o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam logic REG_REPL_CHAR = 1'b0;

    logic       r_s1_valid;
    logic [7:0] r_s1_byte;
    logic       r_s1_last;
    logic       s1_go;

    logic [7:0] r_repl;

    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_bvalid;
    logic       r_out_eos;
    logic       r_out_status;

    t_feed      feed;
    logic       blocked;
    logic       dec_en;
    logic [7:0] dec_byte;
    logic       dec_status;

    // config port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_REPL_CHAR) ? {{(APB_DATA_W-8){1'b0}}, r_repl}
                                                : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repl <= REPL_CHAR_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_REPL_CHAR)) begin
            r_repl <= pwdata[7:0];
        end
    end

    // input register
    assign s1_go      = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_s1_byte <= i_in.in_byte;
            r_s1_last <= i_in.last_in;
        end
    end

    uul1_pct_dec u_pct (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (s1_go),
        .i_byte    (r_s1_byte),
        .i_last    (r_s1_last),
        .i_blocked (blocked),
        .o_feed    (feed)
    );

    uul1_utf8_dec u_utf8 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (s1_go),
        .i_feed     (feed),
        .i_last     (r_s1_last),
        .i_repl     (r_repl),
        .o_blocked  (blocked),
        .o_out_en   (dec_en),
        .o_out_byte (dec_byte),
        .o_status   (dec_status)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go) begin
            r_out_valid <= dec_en || r_s1_last;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_out_byte   <= dec_en ? dec_byte : 8'h00;
            r_out_bvalid <= dec_en;
            r_out_eos    <= r_s1_last;
            r_out_status <= r_s1_last && dec_status;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.latin1_byte   = r_out_byte;
    assign o_out.byte_valid    = r_out_bvalid;
    assign o_out.end_of_string = r_out_eos;
    assign o_out.status        = r_out_status;

endmodule

>>> src/uul1_checker.sv
// ----------------------------------------------------------------------------
// uul1_port_checks
// Port-level checks on the result channel of the converter.
// ----------------------------------------------------------------------------
module uul1_port_checks (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_bvalid,
    input logic       i_out_eos,
    input logic       i_out_status
);

    // a held result keeps its contents
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_byte) && $stable(i_out_bvalid) &&
            $stable(i_out_eos) && $stable(i_out_status))
        else $error("result changed while stalled");

    // error status only on the item closing a string
    a_status_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status |-> i_out_eos)
        else $error("status set on a mid-string item");

    // a mid-string item always carries a byte
    a_mid_has_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_eos |-> i_out_bvalid)
        else $error("empty result item before end of string");

    // empty byte slot reads as zero
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_bvalid |-> i_out_byte == 8'h00)
        else $error("latin1_byte nonzero without byte_valid");

    // nothing comes out in the cycle after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind url_unescape_utf8_to_latin1_top uul1_port_checks u_uul1_port_checks (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_byte   (o_out.latin1_byte),
    .i_out_bvalid (o_out.byte_valid),
    .i_out_eos    (o_out.end_of_string),
    .i_out_status (o_out.status)
);
